FILE: design/psl_pkg.sv
package psl_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DRAIN,
    S_PLACE
  } psl_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [LEN_W-1:0]          length;
  } rsp_t;

  typedef struct packed {
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [DATA_W-1:0]         wdata;
    logic [ADDR_W-1:0]         raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic                      fire;
    rsp_t                      rsp;
  } fin_t;

endpackage

FILE: design/psl_ram.sv
module psl_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/psl_ctrl.sv
module psl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  psl_pkg::req_t             request,
  input  logic [psl_pkg::DATA_W-1:0] rdata,
  output logic                      busy,
  output psl_pkg::mem_cmd_t         mem_cmd,
  output psl_pkg::fin_t             fin
);

  import psl_pkg::*;

  psl_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  kind_t             kind_r, kind_r_next;
  logic [ADDR_W-1:0] pos_r, pos_r_next;
  logic [DATA_W-1:0] val_r, val_r_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;

  logic [CMP_W-1:0]  cnt_x, pos_x, cnt_next_x;
  logic [ADDR_W-1:0] last_idx;
  logic              take, is_ins, shift_last;
  logic              req_ok;
  status_t           req_status;

  assign busy       = (state != S_IDLE);
  assign take       = start && (state == S_IDLE);
  assign cnt_x      = CMP_W'(count);
  assign pos_x      = CMP_W'(request.position);
  assign last_idx   = ADDR_W'(count - CNT_W'(1));
  assign is_ins     = (kind_r == OP_INSERT);
  assign shift_last = is_ins ? (rd_ptr == pos_r) : (rd_ptr == last_idx);
  assign cnt_next_x = CMP_W'(count_next);

  always_comb begin
    req_status = STAT_OK;
    if (request.kind == OP_INSERT) begin
      if (count >= CNT_W'(CAPACITY)) begin
        req_status = STAT_FULL;
      end else if (pos_x > cnt_x) begin
        req_status = STAT_BADPOS;
      end
    end else begin
      if (count == '0) begin
        req_status = STAT_EMPTY;
      end else if (pos_x >= cnt_x) begin
        req_status = STAT_BADPOS;
      end
    end
    req_ok = (req_status == STAT_OK);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && req_ok) begin
          case (request.kind)
            OP_INSERT: if (pos_x != cnt_x) state_next = S_SHIFT;
            OP_DELETE: if (pos_x != cnt_x - CMP_W'(1)) state_next = S_SHIFT;
            OP_READ:   state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SHIFT: if (shift_last) state_next = S_DRAIN;
      S_DRAIN: state_next = is_ins ? S_PLACE : S_IDLE;
      S_PLACE: state_next = S_IDLE;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next     = count;
    kind_r_next    = kind_r;
    pos_r_next     = pos_r;
    val_r_next     = val_r;
    rd_ptr_next    = rd_ptr;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    mem_cmd        = '0;
    fin            = '0;
    fin.rsp.status = STAT_OK;
    case (state)
      S_IDLE: begin
        if (take) begin
          kind_r_next    = request.kind;
          pos_r_next     = request.position[ADDR_W-1:0];
          val_r_next     = request.value;
          pend_next      = 1'b0;
          mem_cmd.raddr  = request.position[ADDR_W-1:0];
          fin.fire       = 1'b1;
          fin.rsp.status = req_status;
          if (req_ok) begin
            case (request.kind)
              OP_INSERT: begin
                if (pos_x == cnt_x) begin
                  mem_cmd.we    = 1'b1;
                  mem_cmd.waddr = request.position[ADDR_W-1:0];
                  mem_cmd.wdata = request.value;
                  count_next    = count + CNT_W'(1);
                end else begin
                  fin.fire    = 1'b0;
                  rd_ptr_next = last_idx;
                end
              end
              OP_DELETE: begin
                if (pos_x == cnt_x - CMP_W'(1)) begin
                  count_next = count - CNT_W'(1);
                end else begin
                  fin.fire    = 1'b0;
                  rd_ptr_next = request.position[ADDR_W-1:0] + ADDR_W'(1);
                end
              end
              OP_UPDATE: begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = request.position[ADDR_W-1:0];
                mem_cmd.wdata = request.value;
              end
              default: fin.fire = 1'b0;
            endcase
          end
        end
      end
      S_SHIFT: begin
        mem_cmd.raddr  = rd_ptr;
        mem_cmd.we     = pend;
        mem_cmd.waddr  = pend_addr;
        mem_cmd.wdata  = rdata;
        pend_next      = 1'b1;
        pend_addr_next = is_ins ? rd_ptr + ADDR_W'(1) : rd_ptr - ADDR_W'(1);
        if (!shift_last) begin
          rd_ptr_next = is_ins ? rd_ptr - ADDR_W'(1) : rd_ptr + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pend_addr;
        mem_cmd.wdata = rdata;
        pend_next     = 1'b0;
        if (!is_ins) begin
          count_next = count - CNT_W'(1);
          fin.fire   = 1'b1;
        end
      end
      S_PLACE: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pos_r;
        mem_cmd.wdata = val_r;
        count_next    = count + CNT_W'(1);
        fin.fire      = 1'b1;
      end
      S_READ: begin
        fin.fire           = 1'b1;
        fin.rsp.read_value = rdata;
      end
      default: ;
    endcase
    fin.rsp.length = cnt_next_x[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_r_next;
    pos_r     <= pos_r_next;
    val_r     <= val_r_next;
    rd_ptr    <= rd_ptr_next;
    pend_addr <= pend_addr_next;
  end

endmodule

FILE: design/positional_sequence_list.sv
// Bounded ordered list of up to CAPACITY signed 32-bit entries held in one
// synchronous memory. An item is taken when start is high and busy is low;
// its result shows on result for one cycle with done high, and must be taken
// then. Rejected items, appends, updates, and deletes of the last entry give
// done in the cycle after the item is taken; reads first pass through a read
// state. Insert and delete at a position inside the list move each later
// entry through the memory's single read and single write port, one entry per
// cycle, then write the last moved entry in a drain state; insert then places
// the new value. Busy stays high until that is done. A new item may be taken
// in the cycle its predecessor's result is shown.
module positional_sequence_list (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  psl_pkg::req_t  request,
  output logic           busy,
  output logic           done,
  output psl_pkg::rsp_t  result
);

  import psl_pkg::*;

  mem_cmd_t          mem_cmd;
  fin_t              fin;
  logic [DATA_W-1:0] rdata;

  psl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .rdata   (rdata),
    .busy    (busy),
    .mem_cmd (mem_cmd),
    .fin     (fin)
  );

  psl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .raddr (mem_cmd.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.fire) begin
      result <= fin.rsp;
    end
  end

endmodule

FILE: tb/sv/tb_positional_sequence_list.sv
`timescale 1ns / 100ps
module tb_positional_sequence_list;
  import psl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOWN_MAX   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_len = 0;
  rsp_t                     pending_rsp [$];
  int                       mismatches = 0;
  int                       cycles = 0;
  bit                       idle_on = 1'b1;
  rsp_t                     want;

  positional_sequence_list i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic rsp_t list_apply(req_t it);
    rsp_t r;
    int   p;
    int   i;
    r = '0;
    r.status = STAT_OK;
    p = it.position;
    if (it.kind == OP_INSERT) begin
      if (shadow_len >= CAPACITY) begin
        r.status = STAT_FULL;
      end else if (p > shadow_len) begin
        r.status = STAT_BADPOS;
      end else begin
        for (i = shadow_len; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[p] = it.value;
        shadow_len++;
      end
    end else if (shadow_len == 0) begin
      r.status = STAT_EMPTY;
    end else if (p >= shadow_len) begin
      r.status = STAT_BADPOS;
    end else begin
      case (it.kind)
        OP_DELETE: begin
          for (i = p + 1; i < shadow_len; i++) shadow_entries[i-1] = shadow_entries[i];
          shadow_len--;
        end
        OP_UPDATE: shadow_entries[p] = it.value;
        default:   r.read_value = shadow_entries[p];
      endcase
    end
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected result: status %0d read_value %0d length %0d",
                   result.status, result.read_value, result.length);
      end else begin
        want = pending_rsp.pop_front();
        if (result.status !== want.status || result.read_value !== want.read_value ||
            result.length !== want.length) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display({"mismatch at cycle %0d: status exp %0d got %0d, ",
                      "read_value exp %0d got %0d, length exp %0d got %0d"},
                     cycles, want.status, result.status, want.read_value,
                     result.read_value, want.length, result.length);
        end
      end
    end
  end

  // leave start high on return; the next item may drop it for an idle gap, and the end of stimulus drops it
  task automatic send_item(kind_t k, int unsigned pos, logic [DATA_W-1:0] val);
    req_t it;
    it.kind = k;
    it.position = pos[POS_W-1:0];
    it.value = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(list_apply(it));
  endtask

  function automatic kind_t pick_kind();
    int r;
    int ti;
    int td;
    int tu;
    r = $urandom_range(0, 99);
    if (shadow_len < 16) begin
      ti = 60; td = 75; tu = 85;
    end else if (shadow_len > CAPACITY - 16) begin
      ti = 15; td = 65; tu = 80;
    end else begin
      ti = 35; td = 65; tu = 80;
    end
    if (r < ti) return OP_INSERT;
    if (r < td) return OP_DELETE;
    if (r < tu) return OP_UPDATE;
    return OP_READ;
  endfunction

  function automatic int unsigned pick_pos(kind_t k);
    int lim;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    lim = (k == OP_INSERT) ? shadow_len : shadow_len - 1;
    if (lim < 0) return $urandom_range(0, 255);
    return $urandom_range(0, lim);
  endfunction

  task automatic send_random();
    kind_t k;
    k = pick_kind();
    send_item(k, pick_pos(k), $urandom());
  endtask

  task automatic test_edges();
    send_item(OP_READ, 0, 32'h0000_0001);
    send_item(OP_DELETE, 255, 32'h0);
    send_item(OP_UPDATE, 0, 32'hffff_ffff);
    send_item(OP_INSERT, 1, 32'h1);
    send_item(OP_INSERT, 255, 32'h2);
    send_item(OP_INSERT, 0, 32'h7fff_ffff);
    send_item(OP_INSERT, 1, 32'h8000_0000);
    send_item(OP_INSERT, 0, 32'h0);
    send_item(OP_INSERT, 1, 32'hffff_ffff);
    send_item(OP_INSERT, 4, 32'h5555_5555);
    send_item(OP_INSERT, 5, 32'haaaa_aaaa);
    for (int i = 0; i < 6; i++) send_item(OP_READ, i, 32'hffff_ffff);
    send_item(OP_UPDATE, 6, 32'h1234_5678);
    send_item(OP_READ, 6, 32'h0);
    send_item(OP_DELETE, 255, 32'h0);
    send_item(OP_UPDATE, 0, 32'h8000_0000);
    send_item(OP_DELETE, 0, 32'h0);
    send_item(OP_DELETE, 2, 32'h0);
    send_item(OP_DELETE, 3, 32'h0);
    send_item(OP_READ, 0, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_len < CAPACITY)
      send_item(OP_INSERT, $urandom_range(0, shadow_len), $urandom());
    send_item(OP_INSERT, 0, $urandom());
    send_item(OP_INSERT, 255, $urandom());
    send_item(OP_READ, CAPACITY - 1, 32'h0);
    send_item(OP_READ, CAPACITY, 32'h0);
    send_item(OP_UPDATE, CAPACITY - 1, $urandom());
    send_item(OP_READ, CAPACITY - 1, 32'h0);
    while (shadow_len > 0) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_READ, $urandom_range(0, shadow_len - 1), $urandom());
      else
        send_item(OP_DELETE, $urandom_range(0, shadow_len - 1), $urandom());
    end
    send_item(OP_DELETE, 0, 32'h0);
  endtask

  task automatic test_random_mix(int n);
    repeat (n) send_random();
  endtask

  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    repeat (n) send_random();
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_entries[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_edges();
    test_fill_and_drain();
    test_random_mix(450);
    test_back_to_back(160);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
